@@ rtl/dwrp_pkg.sv @@
// Shared types and constants for the dual wheel ramped PID speed controller.
package dwrp_pkg;

  localparam int GAIN_FRAC_BITS = 8;

  localparam int GAIN_W   = 12;
  localparam int STEP_W   = 15;
  localparam int SCALE_W  = 12;
  localparam int SPEED_W  = 16;
  localparam int SUM_W    = 32;
  localparam int ERR_W    = 24;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int PROD_W   = SPEED_W + SCALE_W + 1;
  localparam int MEAS_W   = PROD_W - GAIN_FRAC_BITS;
  localparam int ACC_W    = 46;
  localparam int QUOT_W   = ACC_W - GAIN_FRAC_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_SCALE = 3'd4;

  localparam logic signed [GAIN_W-1:0] RST_GAIN_P      = 12'sd128;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_I      = 12'sd77;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_D      = -12'sd51;
  localparam logic [STEP_W-1:0]        RST_RAMP_STEP   = 15'd100;
  localparam logic [SCALE_W-1:0]       RST_COUNT_SCALE = 12'd256;

  // direction codes
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [STEP_W-1:0]        ramp_step;
    logic [SCALE_W-1:0]       count_scale;
  } cfg_t;

  // one strobe per lane step
  typedef struct packed {
    logic load;
    logic st1;
    logic st2;
    logic st3;
  } lane_ctrl_t;

endpackage

@@ rtl/dwrp_lane.sv @@
// One wheel lane: setpoint ramp, speed measurement and PID arithmetic over four steps.
module dwrp_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dwrp_pkg::lane_ctrl_t                 ctrl,
  input  dwrp_pkg::cfg_t                       cfg,
  input  logic signed [dwrp_pkg::SPEED_W-1:0]  target,
  input  logic signed [dwrp_pkg::SPEED_W-1:0]  delta,
  output logic signed [dwrp_pkg::SPEED_W-1:0]  drive
);

  localparam int F = dwrp_pkg::GAIN_FRAC_BITS;

  // wheel state
  logic signed [dwrp_pkg::SPEED_W-1:0] setpoint;
  logic signed [dwrp_pkg::SUM_W-1:0]   error_sum;
  logic signed [dwrp_pkg::ERR_W-1:0]   last_error;

  // working registers
  logic signed [dwrp_pkg::SPEED_W-1:0] target_r;
  logic signed [dwrp_pkg::SPEED_W-1:0] delta_r;
  logic signed [dwrp_pkg::PROD_W-1:0]  prod;
  logic signed [dwrp_pkg::ERR_W-1:0]   err_r;
  logic signed [dwrp_pkg::DIFF_W-1:0]  diff_r;
  logic signed [dwrp_pkg::GAIN_W+dwrp_pkg::ERR_W-1:0]  pp;
  logic signed [dwrp_pkg::GAIN_W+dwrp_pkg::SUM_W-1:0]  pi;
  logic signed [dwrp_pkg::GAIN_W+dwrp_pkg::DIFF_W-1:0] pd;

  logic signed [dwrp_pkg::GAIN_W-1:0]  gain_p;
  logic signed [dwrp_pkg::GAIN_W-1:0]  gain_i;
  logic signed [dwrp_pkg::GAIN_W-1:0]  gain_d;
  logic signed [dwrp_pkg::SCALE_W:0]   scale_s;

  logic signed [dwrp_pkg::SPEED_W+1:0] sp_w, tgt_w, step_w, sp_step;
  logic signed [dwrp_pkg::SPEED_W-1:0] setpoint_next;
  logic signed [dwrp_pkg::PROD_W-1:0]  prod_adj;
  logic signed [dwrp_pkg::MEAS_W-1:0]  meas;
  logic signed [31:0]                  err_wide;
  logic signed [dwrp_pkg::ERR_W-1:0]   err;
  logic signed [dwrp_pkg::SUM_W:0]     sum_wide;
  logic signed [dwrp_pkg::SUM_W-1:0]   sum;
  logic signed [dwrp_pkg::ACC_W-1:0]   acc, acc_adj;
  logic signed [dwrp_pkg::QUOT_W-1:0]  quot;

  assign gain_p  = cfg.gain_p;
  assign gain_i  = cfg.gain_i;
  assign gain_d  = cfg.gain_d;
  assign scale_s = $signed({1'b0, cfg.count_scale});

  // ramp toward the target, clipped so it never overshoots
  always_comb begin
    sp_w   = (dwrp_pkg::SPEED_W+2)'(setpoint);
    tgt_w  = (dwrp_pkg::SPEED_W+2)'(target_r);
    step_w = $signed({3'b000, cfg.ramp_step});
    sp_step = sp_w;
    if (sp_w > tgt_w) begin
      sp_step = sp_w - step_w;
      if (sp_step < tgt_w) sp_step = tgt_w;
    end else if (sp_w < tgt_w) begin
      sp_step = sp_w + step_w;
      if (sp_step > tgt_w) sp_step = tgt_w;
    end
    setpoint_next = sp_step[dwrp_pkg::SPEED_W-1:0];
  end

  // measured speed, truncated toward zero, then error and integral with saturation
  always_comb begin
    prod_adj = prod + $signed({{(dwrp_pkg::PROD_W-F){1'b0}}, {F{prod[dwrp_pkg::PROD_W-1]}}});
    meas     = prod_adj[dwrp_pkg::PROD_W-1:F];
    err_wide = 32'(setpoint) - 32'(meas);
    if (err_wide > 32'sd8388607)       err = 24'sh7FFFFF;
    else if (err_wide < -32'sd8388608) err = 24'sh800000;
    else                               err = err_wide[dwrp_pkg::ERR_W-1:0];
    sum_wide = (dwrp_pkg::SUM_W+1)'(error_sum) + (dwrp_pkg::SUM_W+1)'(err);
    if (sum_wide[dwrp_pkg::SUM_W] != sum_wide[dwrp_pkg::SUM_W-1])
      sum = sum_wide[dwrp_pkg::SUM_W] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else
      sum = sum_wide[dwrp_pkg::SUM_W-1:0];
  end

  // sum of the three terms, truncated toward zero and saturated
  always_comb begin
    acc = dwrp_pkg::ACC_W'(pp) + dwrp_pkg::ACC_W'(pi) + dwrp_pkg::ACC_W'(pd);
    acc_adj = acc + $signed({{(dwrp_pkg::ACC_W-F){1'b0}}, {F{acc[dwrp_pkg::ACC_W-1]}}});
    quot = acc_adj[dwrp_pkg::ACC_W-1:F];
    if (quot > dwrp_pkg::QUOT_W'(32767))       drive = 16'sh7FFF;
    else if (quot < -dwrp_pkg::QUOT_W'(32768)) drive = 16'sh8000;
    else                                       drive = quot[dwrp_pkg::SPEED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= '0;
      error_sum  <= '0;
      last_error <= '0;
    end else begin
      if (ctrl.st1) begin
        setpoint <= setpoint_next;
        if (target_r == '0) begin
          error_sum  <= '0;
          last_error <= '0;
        end
      end
      if (ctrl.st2) begin
        error_sum  <= sum;
        last_error <= err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      target_r <= target;
      delta_r  <= delta;
    end
    if (ctrl.st1) prod <= delta_r * scale_s;
    if (ctrl.st2) begin
      err_r  <= err;
      diff_r <= dwrp_pkg::DIFF_W'(err) - dwrp_pkg::DIFF_W'(last_error);
    end
    // error_sum already holds the new integral here
    if (ctrl.st3) begin
      pp <= gain_p * err_r;
      pi <= gain_i * error_sum;
      pd <= gain_d * diff_r;
    end
  end

endmodule

@@ rtl/dwrp_out.sv @@
// Merge stage: direction and PWM from both lanes' drives, held in the output register.
module dwrp_out (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic signed [dwrp_pkg::SPEED_W-1:0] lane_drive_right,
  input  logic signed [dwrp_pkg::SPEED_W-1:0] lane_drive_left,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [dwrp_pkg::SPEED_W-1:0] drive_right,
  output logic signed [dwrp_pkg::SPEED_W-1:0] drive_left,
  output logic [7:0]                          pwm_right,
  output logic [7:0]                          pwm_left,
  output logic [1:0]                          dir_right,
  output logic [1:0]                          dir_left
);

  logic [dwrp_pkg::SPEED_W:0] mag_right, mag_left;
  logic [7:0] pwm_right_next, pwm_left_next;
  logic [1:0] dir_right_next, dir_left_next;

  always_comb begin
    mag_right = lane_drive_right[dwrp_pkg::SPEED_W-1]
              ? (dwrp_pkg::SPEED_W+1)'(-(dwrp_pkg::SPEED_W+1)'(lane_drive_right))
              : (dwrp_pkg::SPEED_W+1)'(lane_drive_right);
    mag_left  = lane_drive_left[dwrp_pkg::SPEED_W-1]
              ? (dwrp_pkg::SPEED_W+1)'(-(dwrp_pkg::SPEED_W+1)'(lane_drive_left))
              : (dwrp_pkg::SPEED_W+1)'(lane_drive_left);
    pwm_right_next = (mag_right > 17'd255) ? 8'd255 : mag_right[7:0];
    pwm_left_next  = (mag_left > 17'd255) ? 8'd255 : mag_left[7:0];
    if (lane_drive_right == '0)                        dir_right_next = dwrp_pkg::DIR_STOP;
    else if (lane_drive_right[dwrp_pkg::SPEED_W-1])    dir_right_next = dwrp_pkg::DIR_REV;
    else                                               dir_right_next = dwrp_pkg::DIR_FWD;
    if (lane_drive_left == '0)                         dir_left_next = dwrp_pkg::DIR_STOP;
    else if (lane_drive_left[dwrp_pkg::SPEED_W-1])     dir_left_next = dwrp_pkg::DIR_REV;
    else                                               dir_left_next = dwrp_pkg::DIR_FWD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_right <= lane_drive_right;
      drive_left  <= lane_drive_left;
      pwm_right   <= pwm_right_next;
      pwm_left    <= pwm_left_next;
      dir_right   <= dir_right_next;
      dir_left    <= dir_left_next;
    end
  end

endmodule

@@ rtl/dual_wheel_ramped_pid_speed.sv @@
// Top level: configuration registers, step sequencer, two wheel lanes and the merge stage.
//
//   channel  signals                                         handshake
//   in       target_right/left, delta_right/left             in_valid / in_stall
//   out      drive_*, pwm_*, dir_* (right, left)             out_valid / out_stall
//   cfg      cfg_index, cfg_data                             cfg_we, no wait
//
// From acceptance to a result in the output register, an item passes through
// four lane steps (measure product, error and integral, three gain multiplies, sum).
// One item is in the lanes at a time; the next is taken the cycle after the result is
// registered, even while that result is stalled.
// A stalled output holds the lanes in their final step until the register frees.
// rst is synchronous and holds in_stall high: gains, ramp step and count scale go to their
// defaults, wheel state to zero.
module dual_wheel_ramped_pid_speed (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [dwrp_pkg::SPEED_W-1:0] target_right,
  input  logic signed [dwrp_pkg::SPEED_W-1:0] target_left,
  input  logic signed [dwrp_pkg::SPEED_W-1:0] delta_right,
  input  logic signed [dwrp_pkg::SPEED_W-1:0] delta_left,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [dwrp_pkg::SPEED_W-1:0] drive_right,
  output logic signed [dwrp_pkg::SPEED_W-1:0] drive_left,
  output logic [7:0]                          pwm_right,
  output logic [7:0]                          pwm_left,
  output logic [1:0]                          dir_right,
  output logic [1:0]                          dir_left,
  input  logic                                cfg_we,
  input  logic [dwrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dwrp_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_S1   = 3'd1;
  localparam logic [2:0] ST_S2   = 3'd2;
  localparam logic [2:0] ST_S3   = 3'd3;
  localparam logic [2:0] ST_S4   = 3'd4;

  logic [2:0] state, state_next;
  dwrp_pkg::cfg_t       cfg;
  dwrp_pkg::lane_ctrl_t ctrl;
  logic out_load;
  logic in_accept;
  logic signed [dwrp_pkg::SPEED_W-1:0] lane_drive_right, lane_drive_left;

  assign in_stall  = rst || (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p      <= dwrp_pkg::RST_GAIN_P;
      cfg.gain_i      <= dwrp_pkg::RST_GAIN_I;
      cfg.gain_d      <= dwrp_pkg::RST_GAIN_D;
      cfg.ramp_step   <= dwrp_pkg::RST_RAMP_STEP;
      cfg.count_scale <= dwrp_pkg::RST_COUNT_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dwrp_pkg::REG_GAIN_P:      cfg.gain_p      <= cfg_data[dwrp_pkg::GAIN_W-1:0];
        dwrp_pkg::REG_GAIN_I:      cfg.gain_i      <= cfg_data[dwrp_pkg::GAIN_W-1:0];
        dwrp_pkg::REG_GAIN_D:      cfg.gain_d      <= cfg_data[dwrp_pkg::GAIN_W-1:0];
        dwrp_pkg::REG_RAMP_STEP:   cfg.ramp_step   <= cfg_data[dwrp_pkg::STEP_W-1:0];
        dwrp_pkg::REG_COUNT_SCALE: cfg.count_scale <= cfg_data[dwrp_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ctrl.load = in_accept;
        if (in_accept) state_next = ST_S1;
      end
      ST_S1: begin
        ctrl.st1   = 1'b1;
        state_next = ST_S2;
      end
      ST_S2: begin
        ctrl.st2   = 1'b1;
        state_next = ST_S3;
      end
      ST_S3: begin
        ctrl.st3   = 1'b1;
        state_next = ST_S4;
      end
      ST_S4: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  dwrp_lane u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .target (target_right),
    .delta  (delta_right),
    .drive  (lane_drive_right)
  );

  dwrp_lane u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .target (target_left),
    .delta  (delta_left),
    .drive  (lane_drive_left)
  );

  dwrp_out u_out (
    .clk              (clk),
    .rst              (rst),
    .load             (out_load),
    .lane_drive_right (lane_drive_right),
    .lane_drive_left  (lane_drive_left),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .drive_right      (drive_right),
    .drive_left       (drive_left),
    .pwm_right        (pwm_right),
    .pwm_left         (pwm_left),
    .dir_right        (dir_right),
    .dir_left         (dir_left)
  );

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == ST_S1)
    else $error("accepted item did not start the lanes");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && state == ST_IDLE)
    else $error("finished item not held at the output");

  a_dir_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((dir_right == dwrp_pkg::DIR_STOP) == (drive_right == '0)) &&
                  ((dir_left == dwrp_pkg::DIR_STOP) == (drive_left == '0)))
    else $error("direction code disagrees with drive");

  a_pwm_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pwm_right == '0) == (drive_right == '0)) &&
                  ((pwm_left == '0) == (drive_left == '0)))
    else $error("pwm magnitude disagrees with drive");

endmodule
